[sv/assert_macros.svh]
// Assertion macros used by the console datapath.
// Clocked on the rising edge, quiet while reset is asserted (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define TCA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("console assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define TCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("console assertion failed");

`endif

[sv/tca_pkg.sv]
// Shared constants, types and helper functions of the text console.
// No dependencies; every other console file except assert_macros.svh imports this package.
`default_nettype none

package tca_pkg;

	// Screen geometry and parser buffer sizes
	localparam int SCREEN_COLUMNS = 80;
	localparam int SCREEN_ROWS    = 25;
	localparam int MAX_DIGITS     = 4;
	localparam int MAX_CODES      = 4;

	// Field widths
	localparam int CHAR_W  = 8;
	localparam int KIND_W  = 2;
	localparam int ADDR_W  = 11;
	localparam int VALUE_W = 16;
	localparam int COLOR_W = 4;
	localparam int DIGIT_W = 4;
	localparam int CODE_W  = 14;
	localparam int ACC_W   = CODE_W + 4;

	localparam int COL_W  = $clog2(SCREEN_COLUMNS);
	localparam int ROW_W  = $clog2(SCREEN_ROWS);
	localparam int DCNT_W = $clog2(MAX_DIGITS + 1);
	localparam int CCNT_W = $clog2(MAX_CODES + 1);
	localparam int CIDX_W = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;
	localparam int MUL_W  = ROW_W + COL_W + ADDR_W;

	localparam int TAB_STEP     = 8;
	localparam int DECIMAL_BASE = 10;
	localparam int CODE_LIMIT   = 16383;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_CELL   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SCROLL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CURSOR = 2'd2;

	// Character codes
	localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_ESC   = 8'h1B;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_SEMI  = 8'h3B;
	localparam logic [CHAR_W-1:0] CHAR_LBRK  = 8'h5B;
	localparam logic [CHAR_W-1:0] CHAR_M     = 8'h6D;
	localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'h7F;

	// Colors
	localparam logic [COLOR_W-1:0] FG_DEFAULT = 4'd7;
	localparam logic [COLOR_W-1:0] BG_DEFAULT = 4'd0;

	// SGR codes
	localparam logic [CODE_W-1:0] SGR_RESET      = 14'd0;
	localparam logic [CODE_W-1:0] SGR_BOLD       = 14'd1;
	localparam logic [CODE_W-1:0] SGR_FG_FIRST   = 14'd30;
	localparam logic [CODE_W-1:0] SGR_FG_LAST    = 14'd37;
	localparam logic [CODE_W-1:0] SGR_FG_DEFAULT = 14'd39;
	localparam logic [CODE_W-1:0] SGR_BG_FIRST   = 14'd40;
	localparam logic [CODE_W-1:0] SGR_BG_LAST    = 14'd47;
	localparam logic [CODE_W-1:0] SGR_BG_DEFAULT = 14'd49;

	// Commands from controller to datapath
	typedef struct packed {
		logic              take_in;
		logic              apply;
		logic              load_out;
		logic [KIND_W-1:0] out_kind;
	} tca_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic in_valid;
		logic esc_active;
		logic in_is_esc;
		logic in_is_m;
		logic in_printable;
		logic scroll_now;
		logic scroll_pending;
		logic out_free;
		logic apply_last;
	} tca_status_t;

	// ANSI color index to VGA palette index, dark form
	function automatic logic [COLOR_W-1:0] dark_color(input logic [2:0] idx);
		logic [COLOR_W-1:0] c;
		case (idx)
			3'd0: c = 4'd0;
			3'd1: c = 4'd4;
			3'd2: c = 4'd2;
			3'd3: c = 4'd6;
			3'd4: c = 4'd1;
			3'd5: c = 4'd5;
			3'd6: c = 4'd3;
			default: c = 4'd7;
		endcase
		return c;
	endfunction

	// Linear cell address, wrapped to the address field
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		logic [MUL_W-1:0] lin;
		lin = MUL_W'(row) * MUL_W'(SCREEN_COLUMNS) + MUL_W'(col);
		return lin[ADDR_W-1:0];
	endfunction

endpackage

`default_nettype wire

[sv/tca_in_if.sv]
// Character input channel: valid/ready handshake carrying one byte.
// Depends on tca_pkg for the field width.
`default_nettype none

interface tca_in_if import tca_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink   (input valid, input char_byte, output ready);
endinterface

`default_nettype wire

[sv/tca_out_if.sv]
// Result output channel: valid/ready handshake carrying one console request.
// Depends on tca_pkg for the field widths.
`default_nettype none

interface tca_out_if import tca_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  result_kind;
	logic [ADDR_W-1:0]  cell_address;
	logic [VALUE_W-1:0] cell_value;
	logic               last_result;

	modport source (output valid, output result_kind, output cell_address,
		output cell_value, output last_result, input ready);
	modport sink   (input valid, input result_kind, input cell_address,
		input cell_value, input last_result, output ready);
endinterface

`default_nettype wire

[sv/tca_ctrl.sv]
// Sequencing controller of the text console: accept, emit and SGR apply steps.
// Depends on tca_pkg for the command and status types.
`default_nettype none

module tca_ctrl import tca_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire tca_status_t status,
	output tca_cmd_t         cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CELL   = 3'd1;
	localparam logic [2:0] S_SCROLL = 3'd2;
	localparam logic [2:0] S_CURSOR = 3'd3;
	localparam logic [2:0] S_APPLY  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Decode state into commands and pick the next state
	always_comb begin
		state_d      = state_q;
		cmd.take_in  = 1'b0;
		cmd.apply    = 1'b0;
		cmd.load_out = 1'b0;
		cmd.out_kind = KIND_CURSOR;
		unique case (state_q)
			S_IDLE: begin
				cmd.take_in = 1'b1;
				if (status.in_valid) begin
					if (status.esc_active) begin
						if (status.in_is_m) state_d = S_APPLY;
					end else if (!status.in_is_esc) begin
						if (status.in_printable) state_d = S_CELL;
						else if (status.scroll_now) state_d = S_SCROLL;
						else state_d = S_CURSOR;
					end
				end
			end
			S_CELL: begin
				cmd.out_kind = KIND_CELL;
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d = status.scroll_pending ? S_SCROLL : S_CURSOR;
				end
			end
			S_SCROLL: begin
				cmd.out_kind = KIND_SCROLL;
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_CURSOR;
				end
			end
			S_CURSOR: begin
				cmd.out_kind = KIND_CURSOR;
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				if (status.apply_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[sv/tca_datapath.sv]
// Datapath of the text console: cursor, colors, escape parser, output register.
// Depends on tca_pkg, the channel interfaces and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tca_datapath import tca_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire tca_cmd_t cmd,
	output tca_status_t   status,
	tca_in_if.sink        chars,
	tca_out_if.source     results
);

	// Architectural state
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [COLOR_W-1:0] fg_q;
	logic [COLOR_W-1:0] bg_q;
	logic               bold_q;
	logic               esc_q;
	logic [DCNT_W-1:0]  dcount_q;
	logic [CCNT_W-1:0]  ccount_q;
	logic [CODE_W-1:0]  acc_q;
	logic [CODE_W-1:0]  code_store_q [MAX_CODES];
	logic [CIDX_W-1:0]  apply_idx_q;

	// Staged request of the byte in flight
	logic [ADDR_W-1:0]  cell_addr_q;
	logic [VALUE_W-1:0] cell_value_q;
	logic               scroll_q;

	// Output register
	logic               out_valid_q;
	logic [KIND_W-1:0]  out_kind_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [VALUE_W-1:0] out_value_q;
	logic               out_last_q;

	logic [CHAR_W-1:0]  c;
	logic               accept;
	logic               is_digit;
	logic               printable;
	logic [COL_W:0]     col_t;
	logic [COL_W:0]     tab_sum;
	logic [ROW_W:0]     row_t;
	logic               scroll_now;
	logic [COL_W-1:0]   col_n;
	logic [ROW_W-1:0]   row_n;
	logic [ACC_W-1:0]   acc_sum;
	logic [CODE_W-1:0]  acc_n;
	logic [CODE_W-1:0]  code;
	logic [COLOR_W-1:0] fg_a;
	logic [COLOR_W-1:0] bg_a;
	logic               bold_a;
	logic               code_room;
	logic               out_free;

	assign c         = chars.char_byte;
	assign accept    = chars.valid && cmd.take_in;
	assign is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	assign printable = (c >= CHAR_SPACE) && (c <= CHAR_DEL);
	assign code_room = ccount_q < CCNT_W'(MAX_CODES);
	assign out_free  = !out_valid_q || results.ready;

	// Move the cursor for a byte outside an escape sequence
	always_comb begin
		col_t   = {1'b0, col_q};
		row_t   = {1'b0, row_q};
		tab_sum = {1'b0, col_q} + (COL_W+1)'(TAB_STEP);
		if (c == CHAR_BS) begin
			if (col_q != '0) col_t = col_t - (COL_W+1)'(1);
			else if (row_q != '0) row_t = row_t - (ROW_W+1)'(1);
		end else if (c == CHAR_TAB) begin
			col_t = tab_sum & ~(COL_W+1)'(TAB_STEP - 1);
		end else if (c == CHAR_CR) begin
			col_t = '0;
		end else if (c == CHAR_LF) begin
			col_t = '0;
			row_t = row_t + (ROW_W+1)'(1);
		end else if (printable) begin
			col_t = col_t + (COL_W+1)'(1);
		end
		// wrap past the last column
		if (col_t >= (COL_W+1)'(SCREEN_COLUMNS)) begin
			col_t = col_t - (COL_W+1)'(SCREEN_COLUMNS);
			row_t = row_t + (ROW_W+1)'(1);
		end
		scroll_now = row_t >= (ROW_W+1)'(SCREEN_ROWS);
		col_n = col_t[COL_W-1:0];
		row_n = scroll_now ? ROW_W'(SCREEN_ROWS - 1) : row_t[ROW_W-1:0];
	end

	// Fold one decimal digit into the running code, saturating
	always_comb begin
		acc_sum = ACC_W'(acc_q) * ACC_W'(DECIMAL_BASE) + ACC_W'(DIGIT_W'(c - CHAR_ZERO));
		acc_n   = (acc_sum > ACC_W'(CODE_LIMIT)) ? CODE_W'(CODE_LIMIT) : acc_sum[CODE_W-1:0];
	end

	// Apply one stored SGR code
	always_comb begin
		code   = code_store_q[apply_idx_q];
		fg_a   = fg_q;
		bg_a   = bg_q;
		bold_a = bold_q;
		if (code == SGR_RESET) begin
			fg_a   = FG_DEFAULT;
			bg_a   = BG_DEFAULT;
			bold_a = 1'b0;
		end else if (code == SGR_BOLD) begin
			fg_a   = fg_q | 4'b1000;
			bold_a = 1'b1;
		end else if ((code >= SGR_FG_FIRST) && (code <= SGR_FG_LAST)) begin
			fg_a = dark_color(3'(code - SGR_FG_FIRST)) | {bold_q, 3'b000};
		end else if (code == SGR_FG_DEFAULT) begin
			fg_a = FG_DEFAULT;
		end else if ((code >= SGR_BG_FIRST) && (code <= SGR_BG_LAST)) begin
			bg_a = dark_color(3'(code - SGR_BG_FIRST));
		end else if (code == SGR_BG_DEFAULT) begin
			bg_a = BG_DEFAULT;
		end
	end

	// Control state: cursor, colors, parser counters, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			fg_q        <= FG_DEFAULT;
			bg_q        <= BG_DEFAULT;
			bold_q      <= 1'b0;
			esc_q       <= 1'b0;
			dcount_q    <= '0;
			ccount_q    <= '0;
			apply_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (esc_q) begin
					if (is_digit) begin
						if (dcount_q < DCNT_W'(MAX_DIGITS)) dcount_q <= dcount_q + DCNT_W'(1);
					end else if ((c == CHAR_SEMI) || (c == CHAR_M)) begin
						dcount_q <= '0;
						if (code_room) ccount_q <= ccount_q + CCNT_W'(1);
						apply_idx_q <= '0;
					end else if (c != CHAR_LBRK) begin
						dcount_q <= '0;
						ccount_q <= '0;
						esc_q    <= 1'b0;
					end
				end else if (c == CHAR_ESC) begin
					esc_q    <= 1'b1;
					dcount_q <= '0;
					ccount_q <= '0;
				end else begin
					col_q <= col_n;
					row_q <= row_n;
				end
			end
			// step through the stored codes, then close the sequence
			if (cmd.apply) begin
				fg_q        <= fg_a;
				bg_q        <= bg_a;
				bold_q      <= bold_a;
				apply_idx_q <= apply_idx_q + CIDX_W'(1);
				if (status.apply_last) begin
					ccount_q <= '0;
					dcount_q <= '0;
					esc_q    <= 1'b0;
				end
			end
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (results.ready) out_valid_q <= 1'b0;
		end
	end

	// Payload: digit accumulator, code store, staged request, output fields
	always_ff @(posedge clk) begin
		if (accept) begin
			if (esc_q) begin
				if (is_digit) begin
					if (dcount_q < DCNT_W'(MAX_DIGITS)) acc_q <= acc_n;
				end else if ((c == CHAR_SEMI) || (c == CHAR_M)) begin
					if (code_room) code_store_q[ccount_q[CIDX_W-1:0]] <= acc_q;
					acc_q <= '0;
				end
			end else if (c == CHAR_ESC) begin
				acc_q <= '0;
			end else begin
				cell_addr_q  <= cell_addr(row_q, col_q);
				cell_value_q <= {bg_q, fg_q, c};
				scroll_q     <= scroll_now;
			end
		end
		if (cmd.load_out) begin
			out_kind_q <= cmd.out_kind;
			out_last_q <= (cmd.out_kind == KIND_CURSOR);
			unique case (cmd.out_kind)
				KIND_CELL: begin
					out_addr_q  <= cell_addr_q;
					out_value_q <= cell_value_q;
				end
				KIND_SCROLL: begin
					out_addr_q  <= '0;
					out_value_q <= {bg_q, bg_q, CHAR_SPACE};
				end
				default: begin
					out_addr_q  <= cell_addr(row_q, col_q);
					out_value_q <= '0;
				end
			endcase
		end
	end

	// Drive the channels and the status
	assign chars.ready          = cmd.take_in;
	assign results.valid        = out_valid_q;
	assign results.result_kind  = out_kind_q;
	assign results.cell_address = out_addr_q;
	assign results.cell_value   = out_value_q;
	assign results.last_result  = out_last_q;

	assign status.in_valid       = chars.valid;
	assign status.esc_active     = esc_q;
	assign status.in_is_esc      = (c == CHAR_ESC);
	assign status.in_is_m        = (c == CHAR_M);
	assign status.in_printable   = printable;
	assign status.scroll_now     = scroll_now;
	assign status.scroll_pending = scroll_q;
	assign status.out_free       = out_free;
	assign status.apply_last     = (CCNT_W'(apply_idx_q) + CCNT_W'(1)) >= ccount_q;

	`TCA_ASSERT_IMP(a_col_in_range, clk, arst_n, 1'b1, col_q < COL_W'(SCREEN_COLUMNS))
	`TCA_ASSERT_IMP(a_codes_bounded, clk, arst_n, 1'b1, ccount_q <= CCNT_W'(MAX_CODES))
	`TCA_ASSERT_IMP(a_apply_in_escape, clk, arst_n, cmd.apply, esc_q && (ccount_q != '0))
	`TCA_ASSERT_IMP(a_load_when_free, clk, arst_n, cmd.load_out, out_free)

endmodule

`default_nettype wire

[sv/text_console_ansi_colour_top.sv]
// Top level of the text console with ANSI SGR colors.
// Depends on tca_pkg, tca_in_if, tca_out_if, tca_ctrl and tca_datapath.
`default_nettype none

// Takes one character byte per request and returns the console requests it causes:
// a cell write for bytes 0x20-0x7F, a scroll-up request with a blank fill word when
// the cursor leaves the last row, and a cursor report, which carries last_result.
// Bytes inside an ESC sequence and ESC itself return nothing; SGR codes 0, 1, 30-37,
// 39, 40-47 and 49 take effect on 'm'. A byte inside an escape sequence needs only
// its accept; 'm' is followed by one apply step per stored code (up to MAX_CODES),
// since codes go through one shared apply step a cycle; any other byte is accepted
// and then emits each of its results in turn through the single output register,
// waiting while that register holds an untaken result. The next byte is taken as soon as the
// cursor report sits in the output register, and a stalled output holds it back.
module text_console_ansi_colour_top import tca_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	tca_in_if.sink    chars,
	tca_out_if.source results
);

	tca_cmd_t    cmd;
	tca_status_t status;

	tca_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	tca_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.chars   (chars),
		.results (results)
	);

endmodule

`default_nettype wire

[tb/text_console_ansi_colour_top_tb.sv]
// Testbench for text_console_ansi_colour_top: streams character bytes with random gaps and
// output stalls, and checks every console request against a predictor of the console.
// Depends on tca_pkg, tca_in_if, tca_out_if and the console RTL.
`default_nettype none

module text_console_ansi_colour_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tca_pkg::*;

	localparam int INPUT_ITEMS  = 430;
	localparam int CYCLE_LIMIT  = 500_000;
	localparam int TAIL_CYCLES  = 16;
	localparam int MAX_GAP      = 19;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [ADDR_W-1:0]  addr;
		logic [VALUE_W-1:0] value;
		logic               last;
	} console_request_t;

	// Predicts the console requests caused by each accepted character byte
	class console_predictor;
		int unsigned        col, row;
		logic [COLOR_W-1:0] fg, bg;
		bit                 bold, seq_open;
		logic [DIGIT_W-1:0] digits [MAX_DIGITS];
		int unsigned        codes [MAX_CODES];
		int unsigned        n_digits, n_codes;
		logic [COLOR_W-1:0] vga_palette [8] = '{4'd0, 4'd4, 4'd2, 4'd6, 4'd1, 4'd5, 4'd3, 4'd7};
		console_request_t   expected_requests [$];
		int unsigned        bytes_handled;
		int unsigned        failures;

		function new();
			col = 0;
			row = 0;
			fg = FG_DEFAULT;
			bg = BG_DEFAULT;
			bold = 1'b0;
			seq_open = 1'b0;
			n_digits = 0;
			n_codes = 0;
			bytes_handled = 0;
			failures = 0;
			foreach (digits[i]) digits[i] = '0;
			foreach (codes[i]) codes[i] = 0;
		endfunction

		task report(string what);
			failures++;
			if (failures <= 100)
				$display("[%0t] mismatch: %s", $realtime, what);
		endtask

		function void push_request(logic [KIND_W-1:0] kind, int unsigned addr,
				logic [VALUE_W-1:0] value, logic last);
			console_request_t r;
			r.kind = kind;
			r.addr = addr[ADDR_W-1:0];
			r.value = value;
			r.last = last;
			expected_requests.push_back(r);
		endfunction

		// Turn the collected digits into one SGR code, saturating large values
		function void close_number();
			int unsigned acc;
			acc = 0;
			for (int i = 0; i < n_digits; i++) begin
				acc = acc * DECIMAL_BASE + digits[i];
				if (acc > CODE_LIMIT)
					acc = CODE_LIMIT;
			end
			if (n_codes < MAX_CODES) begin
				codes[n_codes] = acc;
				n_codes++;
			end
			n_digits = 0;
		endfunction

		function void apply_code(int unsigned code);
			if (code == SGR_RESET) begin
				fg = FG_DEFAULT;
				bg = BG_DEFAULT;
				bold = 1'b0;
			end else if (code == SGR_BOLD) begin
				fg = fg | 4'h8;
				bold = 1'b1;
			end else if (code >= SGR_FG_FIRST && code <= SGR_FG_LAST) begin
				fg = vga_palette[code - SGR_FG_FIRST] | (bold ? 4'h8 : 4'h0);
			end else if (code == SGR_FG_DEFAULT) begin
				fg = FG_DEFAULT;
			end else if (code >= SGR_BG_FIRST && code <= SGR_BG_LAST) begin
				bg = vga_palette[code - SGR_BG_FIRST];
			end else if (code == SGR_BG_DEFAULT) begin
				bg = BG_DEFAULT;
			end
		endfunction

		function void parse_escape_byte(logic [CHAR_W-1:0] c);
			if (c == CHAR_LBRK)
				return;
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				if (n_digits < MAX_DIGITS) begin
					digits[n_digits] = DIGIT_W'(c - CHAR_ZERO);
					n_digits++;
				end
				return;
			end
			if (c == CHAR_SEMI) begin
				close_number();
				return;
			end
			// 'm' applies the stored codes; anything else just ends the sequence
			if (c == CHAR_M) begin
				close_number();
				for (int i = 0; i < n_codes; i++)
					apply_code(codes[i]);
			end
			n_digits = 0;
			n_codes = 0;
			seq_open = 1'b0;
		endfunction

		function void take_char(logic [CHAR_W-1:0] c);
			bytes_handled++;
			if (seq_open) begin
				parse_escape_byte(c);
				return;
			end
			if (c == CHAR_ESC) begin
				seq_open = 1'b1;
				n_digits = 0;
				n_codes = 0;
				return;
			end
			if (c == CHAR_BS) begin
				if (col > 0)
					col--;
				else if (row > 0)
					row--;
			end else if (c == CHAR_TAB) begin
				col = (col + TAB_STEP) & ~(TAB_STEP - 1);
			end else if (c == CHAR_CR) begin
				col = 0;
			end else if (c == CHAR_LF) begin
				col = 0;
				row++;
			end else if (c >= CHAR_SPACE && c <= CHAR_DEL) begin
				push_request(KIND_CELL, row * SCREEN_COLUMNS + col, {bg, fg, c}, 1'b0);
				col++;
			end
			// Wrap the line, then scroll off the bottom
			if (col >= SCREEN_COLUMNS) begin
				col -= SCREEN_COLUMNS;
				row++;
			end
			if (row >= SCREEN_ROWS) begin
				push_request(KIND_SCROLL, 0, {bg, bg, CHAR_SPACE}, 1'b0);
				row = SCREEN_ROWS - 1;
			end
			push_request(KIND_CURSOR, row * SCREEN_COLUMNS + col, '0, 1'b1);
		endfunction

		task check_request(console_request_t got);
			console_request_t want;
			if (expected_requests.size() == 0) begin
				report($sformatf("request kind %0d addr %0d value %h with nothing expected",
					got.kind, got.addr, got.value));
				return;
			end
			want = expected_requests.pop_front();
			if (got.kind !== want.kind)
				report($sformatf("result_kind %0d, expected %0d", got.kind, want.kind));
			if (got.addr !== want.addr)
				report($sformatf("cell_address %0d, expected %0d", got.addr, want.addr));
			if (got.value !== want.value)
				report($sformatf("cell_value %h, expected %h", got.value, want.value));
			if (got.last !== want.last)
				report($sformatf("last_result %b, expected %b", got.last, want.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned cycle_count = 0;
	bit          steady = 1'b0;
	console_predictor console_model = new();

	tca_in_if  char_ch ();
	tca_out_if request_ch ();

	text_console_ansi_colour_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (char_ch.sink),
		.results (request_ch.source)
	);

	always #6 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Predict on accepted bytes, check accepted requests
	always @(posedge clk) begin
		console_request_t got;
		if (arst_n) begin
			if (char_ch.valid && char_ch.ready)
				console_model.take_char(char_ch.char_byte);
			if (request_ch.valid && request_ch.ready) begin
				got.kind = request_ch.result_kind;
				got.addr = request_ch.cell_address;
				got.value = request_ch.cell_value;
				got.last = request_ch.last_result;
				console_model.check_request(got);
			end
		end
	end

	function automatic int unsigned draw_gap();
		if (steady)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	// Stall the result side for a random number of cycles per request
	initial begin
		int unsigned stall;
		request_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				request_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			request_ch.ready <= 1'b1;
			do @(posedge clk); while (!request_ch.valid);
		end
	end

	task automatic send_char(logic [CHAR_W-1:0] c);
		int unsigned gap;
		gap = draw_gap();
		if (gap > 0) begin
			char_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_ch.valid <= 1'b1;
		char_ch.char_byte <= c;
		do @(posedge clk); while (!char_ch.ready);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic send_escape(string body);
		send_char(CHAR_ESC);
		send_text(body);
	endtask

	// Hold the sender until every expected request has come back
	task automatic drain();
		char_ch.valid <= 1'b0;
		do @(posedge clk); while (console_model.expected_requests.size() != 0);
	endtask

	function automatic int unsigned pick_sgr_code();
		case ($urandom_range(0, 9))
			0: return SGR_RESET;
			1: return SGR_BOLD;
			2, 3: return SGR_FG_FIRST + $urandom_range(0, 7);
			4: return SGR_FG_DEFAULT;
			5, 6: return SGR_BG_FIRST + $urandom_range(0, 7);
			7: return SGR_BG_DEFAULT;
			8: return $urandom_range(0, 99);
			default: return $urandom_range(0, 9999);
		endcase
	endfunction

	// Send a decimal number with optional leading zeros; sometimes leave it empty
	task automatic send_number(int unsigned value, int unsigned pad);
		logic [CHAR_W-1:0] text [$];
		int unsigned v;
		if ($urandom_range(0, 15) == 0)
			return;
		v = value;
		do begin
			text.push_front(CHAR_W'(CHAR_ZERO + v % DECIMAL_BASE));
			v = v / DECIMAL_BASE;
		end while (v != 0);
		repeat (pad) text.push_front(CHAR_ZERO);
		foreach (text[i])
			send_char(text[i]);
	endtask

	task automatic send_sgr_sequence();
		int unsigned n_nums;
		send_char(CHAR_ESC);
		if ($urandom_range(0, 7) != 0)
			send_char(CHAR_LBRK);
		n_nums = $urandom_range(1, MAX_CODES + 2);
		for (int k = 0; k < n_nums; k++) begin
			if (k > 0)
				send_char(CHAR_SEMI);
			send_number(pick_sgr_code(), ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
		end
		send_char(CHAR_M);
	endtask

	// Start a sequence and end it with a byte that is not part of SGR syntax
	task automatic send_broken_sequence();
		logic [CHAR_W-1:0] stop;
		int unsigned n;
		send_char(CHAR_ESC);
		n = $urandom_range(0, 5);
		repeat (n) begin
			if ($urandom_range(0, 3) == 0)
				send_char(CHAR_SEMI);
			else
				send_char(CHAR_W'(CHAR_ZERO + $urandom_range(0, 9)));
		end
		do stop = CHAR_W'($urandom_range(0, 255));
		while ((stop >= CHAR_ZERO && stop <= CHAR_NINE) || stop == CHAR_SEMI ||
			stop == CHAR_LBRK || stop == CHAR_M);
		send_char(stop);
	endtask

	task automatic run_directed();
		// backspace at the home position stays put
		send_char(CHAR_BS);
		// printable extremes and ignored bytes
		send_char(CHAR_SPACE);
		send_char(CHAR_DEL);
		send_char(8'h00);
		send_char(8'h80);
		send_char(8'hFF);
		send_char(CHAR_BS);
		send_char(CHAR_TAB);
		send_char(CHAR_CR);
		// backspace at column 0 climbs one row
		send_char(CHAR_LF);
		send_char(CHAR_BS);
		// bold then a bright foreground
		send_escape("[1;35m");
		send_text("x");
		// background color and default foreground
		send_escape("[46;39m");
		send_text("y");
		// empty number resets everything
		send_escape("[m");
		send_text("z");
		// codes past the store are dropped
		send_escape("[31;32;33;34;44m");
		send_text("a");
		// digits past the store are dropped
		send_escape("[00031;99999m");
		// sequence cut short by a stray byte
		send_escape("[1;34x");
		send_text("b");
		// second ESC ends the sequence
		send_char(CHAR_ESC);
		send_char(CHAR_ESC);
		send_text("c");
		send_escape("[42;33m");
		send_escape("[0;49;37m");
		send_text("d");
	endtask

	task automatic run_random();
		int unsigned len, burst;
		bit paused;
		burst = 0;
		paused = 1'b0;
		while (console_model.bytes_handled < INPUT_ITEMS) begin
			// switch between idling and back-to-back stretches
			if (burst == 0) begin
				steady = ($urandom_range(0, 3) == 0);
				burst = $urandom_range(5, 30);
			end
			burst--;
			if (!paused && console_model.bytes_handled > INPUT_ITEMS / 2) begin
				drain();
				paused = 1'b1;
			end
			case ($urandom_range(0, 99)) inside
				[0:44]: begin
					len = $urandom_range(1, 12);
					repeat (len) send_char(CHAR_W'($urandom_range(CHAR_SPACE, CHAR_DEL)));
				end
				[45:59]: begin
					case ($urandom_range(0, 5))
						0: send_char(CHAR_BS);
						1, 2: send_char(CHAR_TAB);
						3: send_char(CHAR_CR);
						default: send_char(CHAR_LF);
					endcase
				end
				[60:79]: send_sgr_sequence();
				[80:89]: send_broken_sequence();
				default: send_char(CHAR_W'($urandom()));
			endcase
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		char_ch.valid <= 1'b0;
		char_ch.char_byte <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (console_model.expected_requests.size() != 0)
			console_model.report($sformatf("%0d expected requests never arrived",
				console_model.expected_requests.size()));
		if (console_model.failures == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
